FILE: rtl/pncl_pkg.sv
package pncl_pkg;

  localparam int PALETTE_DEPTH    = 256;
  localparam int CACHE_INDEX_BITS = 18;

  localparam int PAL_AW      = $clog2(PALETTE_DEPTH);
  localparam int COUNT_W     = $clog2(PALETTE_DEPTH + 1);
  localparam int CACHE_DEPTH = 1 << CACHE_INDEX_BITS;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 24;
  localparam int PEN_W   = 8;
  localparam int CFG_W   = 3;
  localparam int SQ_W    = 16;
  localparam int DIST_W  = 18;
  localparam int EPOCH_W = 8;
  localparam int SLOT_W  = 18;

  // widest channel slice that still fits the cache index
  localparam int EFF_MAX = (CACHE_INDEX_BITS / 3 < 6) ? CACHE_INDEX_BITS / 3 : 6;
  localparam int HB_SPAN = 32;

  localparam logic [CFG_W-1:0]  CHANNEL_BITS_RESET = 3'd5;
  localparam logic [DIST_W-1:0] DIST_START         = 18'd196000;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [EPOCH_W-1:0] tag;
    logic [PEN_W-1:0]   pen;
  } cache_entry_t;

  typedef struct packed {
    logic              valid;
    logic [PAL_AW-1:0] idx;
    logic [DIST_W-1:0] distance;
  } dist_res_t;

  // 4:4:4 input is widened by repeating each nibble
  function automatic logic [COLOR_W-1:0] expand_color(logic [COLOR_W-1:0] c, logic fmt);
    logic [COLOR_W-1:0] v;
    if (fmt) begin
      v = {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
    end else begin
      v = c;
    end
    return v;
  endfunction

  function automatic logic [COLOR_W-1:0] half_color(logic [COLOR_W-1:0] v);
    return {1'b0, v[23:17], 1'b0, v[15:9], 1'b0, v[7:1]};
  endfunction

  // slot = {blue top, green top, red top}, channel width clamped to 4..EFF_MAX
  function automatic logic [CACHE_INDEX_BITS-1:0] cache_slot(logic [COLOR_W-1:0] rgb,
                                                             logic [CFG_W-1:0] cb);
    logic [CFG_W-1:0]  t;
    logic [SLOT_W-1:0] s;
    t = cb;
    if (t < 3'd4) t = 3'd4;
    if (t > CFG_W'(EFF_MAX)) t = CFG_W'(EFF_MAX);
    case (t)
      3'd4:    s = SLOT_W'({rgb[7:4], rgb[15:12], rgb[23:20]});
      3'd5:    s = SLOT_W'({rgb[7:3], rgb[15:11], rgb[23:19]});
      default: s = SLOT_W'({rgb[7:2], rgb[15:10], rgb[23:18]});
    endcase
    return s[CACHE_INDEX_BITS-1:0];
  endfunction

endpackage

FILE: rtl/pncl_palette_mem.sv
module pncl_palette_mem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clear,
  input  logic                           we,
  input  logic [pncl_pkg::PAL_AW-1:0]    waddr,
  input  logic [pncl_pkg::COLOR_W-1:0]   wdata,
  input  logic                           re,
  input  logic [pncl_pkg::PAL_AW-1:0]    raddr,
  output logic [pncl_pkg::COLOR_W-1:0]   rdata
);

  logic [pncl_pkg::COLOR_W-1:0]       mem [pncl_pkg::PALETTE_DEPTH];
  logic [pncl_pkg::PALETTE_DEPTH-1:0] ent_valid;
  logic [pncl_pkg::COLOR_W-1:0]       rd_raw;
  logic                               rd_ok;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_raw <= mem[raddr];
    end
  end

  // entries never written since reset or clear read as zero
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      ent_valid <= '0;
    end else if (we) begin
      ent_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else if (re) begin
      rd_ok <= ent_valid[raddr];
    end
  end

  assign rdata = rd_ok ? rd_raw : '0;

endmodule

FILE: rtl/pncl_cache_mem.sv
module pncl_cache_mem (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [pncl_pkg::CACHE_INDEX_BITS-1:0]  waddr,
  input  pncl_pkg::cache_entry_t                 wdata,
  input  logic                                   re,
  input  logic [pncl_pkg::CACHE_INDEX_BITS-1:0]  raddr,
  output pncl_pkg::cache_entry_t                 rdata
);

  pncl_pkg::cache_entry_t mem [pncl_pkg::CACHE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pncl_dist.sv
module pncl_dist (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           flush,
  input  logic                           in_v,
  input  logic [pncl_pkg::PAL_AW-1:0]    in_idx,
  input  logic [pncl_pkg::COLOR_W-1:0]   entry,
  input  logic [pncl_pkg::COLOR_W-1:0]   target,
  output pncl_pkg::dist_res_t            res
);

  logic                            s1_v;
  logic [pncl_pkg::PAL_AW-1:0]     s1_idx;
  logic [pncl_pkg::SQ_W-1:0]       sq_r, sq_g, sq_b;
  logic                            s2_v;
  logic [pncl_pkg::PAL_AW-1:0]     s2_idx;
  logic [pncl_pkg::DIST_W-1:0]     s2_dist;
  logic [7:0]                      dr, dg, db;

  function automatic logic [7:0] absdiff(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign dr = absdiff(entry[23:16], target[23:16]);
  assign dg = absdiff(entry[15:8],  target[15:8]);
  assign db = absdiff(entry[7:0],   target[7:0]);

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= in_v;
      s2_v <= s1_v;
    end
  end

  // stage 1: per-channel squares, stage 2: sum
  always_ff @(posedge clk) begin
    s1_idx  <= in_idx;
    sq_r    <= pncl_pkg::SQ_W'(dr) * pncl_pkg::SQ_W'(dr);
    sq_g    <= pncl_pkg::SQ_W'(dg) * pncl_pkg::SQ_W'(dg);
    sq_b    <= pncl_pkg::SQ_W'(db) * pncl_pkg::SQ_W'(db);
    s2_idx  <= s1_idx;
    s2_dist <= pncl_pkg::DIST_W'(sq_r) + pncl_pkg::DIST_W'(sq_g) + pncl_pkg::DIST_W'(sq_b);
  end

  assign res.valid    = s2_v;
  assign res.idx      = s2_idx;
  assign res.distance = s2_dist;

endmodule

FILE: rtl/palette_nearest_color_lookup.sv
// Nearest palette color lookup with a pen cache. One input transaction is one
// operation: clear (palette to zero, count to 0), write (one 8:8:8 or nibble-
// expanded 4:4:4 entry, plus an optional half-bright copy at index+32 for
// indexes below 32) or lookup (best pen by least squared RGB distance, first
// minimum wins). Clear and write give no output transaction; a lookup gives
// exactly one, with palette_empty set and pen 0 when the palette holds no
// entries. A write with the half-bright copy writes the copy in state ST_HALF.
// A lookup goes from ST_CREAD to ST_POST on a pen cache hit (straight to
// ST_POST on an empty palette); a miss scans entries 0..count-1 through the
// single palette read port at one entry per cycle behind a read, squares and
// sum pipeline, stopping early on an exact match; ST_POST raises out_valid
// once the output register is free. The cache is indexed by the top
// channel_bits (clamped to 4..6) of blue, green and red and is invalidated by
// any write, clear or channel_bits write by bumping an 8-bit epoch tag. After
// reset, and each time that epoch wraps (every 256th invalidation), the block
// sweeps all 262144 cache entries, one per cycle, and holds in_stall high
// meanwhile; channel_bits writes are still taken during the sweep.
module palette_nearest_color_lookup (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pncl_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pncl_pkg::OP_W-1:0]      opcode,
  input  logic [pncl_pkg::IDX_W-1:0]     entry_index,
  input  logic [pncl_pkg::COLOR_W-1:0]   color,
  input  logic                           color_format,
  input  logic                           half_bright,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pncl_pkg::PEN_W-1:0]     pen,
  output logic                           palette_empty
);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_HALF,
    ST_CREAD,
    ST_SCAN,
    ST_POST
  } state_t;

  state_t                                  state;
  logic [pncl_pkg::CFG_W-1:0]              channel_bits;
  logic [pncl_pkg::COUNT_W-1:0]            count;
  logic [pncl_pkg::EPOCH_W-1:0]            epoch;
  logic                                    sweep_pend;
  logic [pncl_pkg::CACHE_INDEX_BITS-1:0]   sweep_cnt;
  logic [pncl_pkg::COLOR_W-1:0]            look_color;
  logic [pncl_pkg::CACHE_INDEX_BITS-1:0]   look_slot;
  logic [pncl_pkg::COUNT_W-1:0]            issue_cnt;
  logic                                    rd_v;
  logic [pncl_pkg::PAL_AW-1:0]             rd_idx;
  logic [pncl_pkg::PAL_AW-1:0]             best;
  logic [pncl_pkg::DIST_W-1:0]             bestd;
  logic [pncl_pkg::PEN_W-1:0]              res_pen;
  logic                                    res_empty;
  logic [pncl_pkg::PAL_AW-1:0]             hb_addr;
  logic [pncl_pkg::COLOR_W-1:0]            hb_val;

  logic                                    accept;
  logic                                    idx_ok, half_ok;
  logic                                    wr_acc, clr_acc, lk_acc;
  logic                                    invalidate;
  logic [pncl_pkg::COLOR_W-1:0]            wr_color;
  logic [pncl_pkg::COUNT_W-1:0]            wr_count;

  logic                                    pal_we, pal_re;
  logic [pncl_pkg::PAL_AW-1:0]             pal_waddr, pal_raddr;
  logic [pncl_pkg::COLOR_W-1:0]            pal_wdata, pal_rdata;

  logic                                    cache_we, cache_re;
  logic [pncl_pkg::CACHE_INDEX_BITS-1:0]   cache_waddr, cache_raddr;
  pncl_pkg::cache_entry_t                  cache_wdata, crd;
  logic                                    cache_hit;

  pncl_pkg::dist_res_t                     dres;
  logic                                    issue, better, last_ent, scan_done, dist_flush;
  logic [pncl_pkg::PAL_AW-1:0]             cand_pen;

  // ---- input decode ----
  assign in_stall = (state != ST_IDLE) || sweep_pend;
  assign accept   = in_valid && !in_stall;

  assign idx_ok   = 32'(entry_index) < pncl_pkg::PALETTE_DEPTH;
  assign half_ok  = (32'(entry_index) < pncl_pkg::HB_SPAN) &&
                    (32'(entry_index) + pncl_pkg::HB_SPAN < pncl_pkg::PALETTE_DEPTH);
  assign clr_acc  = accept && (opcode == pncl_pkg::OP_CLEAR);
  assign wr_acc   = accept && (opcode == pncl_pkg::OP_WRITE) && idx_ok;
  assign lk_acc   = accept && (opcode == pncl_pkg::OP_LOOKUP);
  assign wr_color = pncl_pkg::expand_color(color, color_format);
  assign wr_count = pncl_pkg::COUNT_W'(entry_index) + pncl_pkg::COUNT_W'(1);

  // every palette change or index-width change drops the cached pens
  assign invalidate = cfg_we || clr_acc || wr_acc;

  // ---- palette port ----
  assign pal_we    = wr_acc || (state == ST_HALF);
  assign pal_waddr = (state == ST_HALF) ? hb_addr : entry_index[pncl_pkg::PAL_AW-1:0];
  assign pal_wdata = (state == ST_HALF) ? hb_val : wr_color;
  assign pal_re    = issue;
  assign pal_raddr = issue_cnt[pncl_pkg::PAL_AW-1:0];

  pncl_palette_mem u_palette (
    .clk   (clk),
    .rst   (rst),
    .clear (clr_acc),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  // ---- scan pipeline: read -> squares -> sum -> compare ----
  assign dist_flush = (state != ST_SCAN) || scan_done;

  pncl_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .flush  (dist_flush),
    .in_v   (rd_v),
    .in_idx (rd_idx),
    .entry  (pal_rdata),
    .target (look_color),
    .res    (dres)
  );

  assign better    = dres.valid && (dres.distance < bestd);
  assign cand_pen  = better ? dres.idx : best;
  assign last_ent  = (pncl_pkg::COUNT_W'(dres.idx) + pncl_pkg::COUNT_W'(1)) == count;
  assign scan_done = (state == ST_SCAN) && dres.valid &&
                     ((better && (dres.distance == '0)) || last_ent);
  assign issue     = (state == ST_SCAN) && (issue_cnt < count) && !scan_done;

  // ---- pen cache port ----
  assign cache_re    = lk_acc && (count != '0);
  assign cache_raddr = pncl_pkg::cache_slot(color, channel_bits);
  assign cache_we    = (state == ST_SWEEP) || scan_done;
  assign cache_waddr = (state == ST_SWEEP) ? sweep_cnt : look_slot;
  assign cache_hit   = crd.valid && (crd.tag == epoch);

  always_comb begin
    cache_wdata = '0;
    if (state != ST_SWEEP) begin
      cache_wdata.valid = 1'b1;
      cache_wdata.tag   = epoch;
      cache_wdata.pen   = pncl_pkg::PEN_W'(cand_pen);
    end
  end

  pncl_cache_mem u_cache (
    .clk   (clk),
    .we    (cache_we),
    .waddr (cache_waddr),
    .wdata (cache_wdata),
    .re    (cache_re),
    .raddr (cache_raddr),
    .rdata (crd)
  );

  // ---- control ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      channel_bits  <= pncl_pkg::CHANNEL_BITS_RESET;
      count         <= '0;
      epoch         <= '0;
      sweep_pend    <= 1'b0;
      sweep_cnt     <= '0;
      rd_v          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      rd_v   <= issue;
      rd_idx <= issue_cnt[pncl_pkg::PAL_AW-1:0];

      if (cfg_we) begin
        channel_bits <= cfg_wdata;
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (sweep_pend) begin
            state      <= ST_SWEEP;
            sweep_cnt  <= '0;
            sweep_pend <= 1'b0;
          end else if (accept) begin
            unique case (opcode)
              pncl_pkg::OP_CLEAR: begin
                count <= '0;
              end
              pncl_pkg::OP_WRITE: begin
                if (idx_ok) begin
                  if (wr_count > count) begin
                    count <= wr_count;
                  end
                  if (half_bright && half_ok) begin
                    hb_addr <= entry_index[pncl_pkg::PAL_AW-1:0] +
                               pncl_pkg::PAL_AW'(pncl_pkg::HB_SPAN);
                    hb_val  <= pncl_pkg::half_color(wr_color);
                    state   <= ST_HALF;
                  end
                end
              end
              pncl_pkg::OP_LOOKUP: begin
                look_color <= color;
                look_slot  <= cache_raddr;
                if (count == '0) begin
                  res_pen   <= '0;
                  res_empty <= 1'b1;
                  state     <= ST_POST;
                end else begin
                  state <= ST_CREAD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_HALF: begin
          state <= ST_IDLE;
        end
        ST_CREAD: begin
          if (cache_hit) begin
            res_pen   <= crd.pen;
            res_empty <= 1'b0;
            state     <= ST_POST;
          end else begin
            issue_cnt <= '0;
            best      <= '0;
            bestd     <= pncl_pkg::DIST_START;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (better) begin
            best  <= dres.idx;
            bestd <= dres.distance;
          end
          if (scan_done) begin
            res_pen   <= pncl_pkg::PEN_W'(cand_pen);
            res_empty <= 1'b0;
            state     <= ST_POST;
          end
        end
        ST_POST: begin
          // output register frees up or is already empty
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            pen           <= res_pen;
            palette_empty <= res_empty;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // epoch wrap would revive stale tags: schedule a full sweep
      if (invalidate) begin
        epoch <= epoch + 1'b1;
        if (epoch == '1) begin
          sweep_pend <= 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_out_from_post: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_POST))
    else $error("output transaction raised outside result posting");

  a_empty_pen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && palette_empty) |-> (pen == '0))
    else $error("empty palette result carries a nonzero pen");

  a_cache_write_src: assert property (@(posedge clk) disable iff (rst)
    cache_we |-> (state == ST_SWEEP || state == ST_SCAN))
    else $error("pen cache written outside sweep or scan");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (pncl_pkg::COUNT_W'(best) < count))
    else $error("best pen beyond color count");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> $past(state == ST_SCAN))
    else $error("palette read in flight outside scan");
`endif

endmodule
